// ----- sv/ldwt_pkg.sv -----
package ldwt_pkg;

   localparam int DURATION_BITS = 16;
   localparam logic [DURATION_BITS-1:0] MAX_UNITS = '1;

   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DAY_TICKS    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNIT_TICKS   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BLINK_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BLINK_ON     = 3'd3;

   localparam logic [31:0] DAY_TICKS_RESET    = 32'd1728000;
   localparam logic [7:0]  UNIT_TICKS_RESET   = 8'd10;
   localparam logic [15:0] BLINK_PERIOD_RESET = 16'd640;
   localparam logic [7:0]  BLINK_ON_RESET     = 8'd1;

   localparam logic [1:0] CODE_IDLE    = 2'd0;
   localparam logic [1:0] CODE_MEASURE = 2'd1;
   localparam logic [1:0] CODE_CONFIRM = 2'd2;
   localparam logic [1:0] CODE_WATER   = 2'd3;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'b0001,
      MODE_MEASURE = 4'b0010,
      MODE_CONFIRM = 4'b0100,
      MODE_WATER   = 4'b1000
   } mode_type;

   typedef struct packed {
      mode_type                 mode;
      logic                     armed;
      logic [DURATION_BITS-1:0] stored_units;
      logic [7:0]               sub_ticks;
      logic [DURATION_BITS-1:0] run_units;
      logic [31:0]              day_count;
      logic [15:0]              blink_count;
      logic                     pending_press;
      logic                     button_prev;
   } state_type;

   typedef struct packed {
      logic [31:0] day_ticks;
      logic [7:0]  unit_ticks;
      logic [15:0] blink_period_ticks;
      logic [7:0]  blink_on_ticks;
   } cfg_type;

   typedef struct packed {
      logic        pump_on;
      logic        led_on;
      logic [1:0]  mode;
      logic [15:0] duration_units;
   } result_type;

   localparam state_type STATE_RESET = '{
      mode: MODE_IDLE, armed: 1'b0, stored_units: '0, sub_ticks: '0, run_units: '0,
      day_count: '0, blink_count: '0, pending_press: 1'b0, button_prev: 1'b0
   };

endpackage

// ----- sv/learned_duration_watering_timer_top.sv -----
// A tick item is accepted per clock cycle while not stalled; its result appears in the result
// register on the next cycle. The sustained rate of one item per cycle without stalls is set by
// the single combinational pass from state registers to result register. An item is taken even
// while a result waits, if that result is taken in the same cycle. Configuration writes are always
// ready and take effect on the next tick; they should only be made while no transfer is in flight.
module learned_duration_watering_timer_top import ldwt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_button_down,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_pump_on,
   output logic                      rsp_led_on,
   output logic [1:0]                rsp_mode,
   output logic [15:0]               rsp_duration_units,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]               csr_data
);

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       req_take;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.day_ticks          <= DAY_TICKS_RESET;
         cfg_ff.unit_ticks         <= UNIT_TICKS_RESET;
         cfg_ff.blink_period_ticks <= BLINK_PERIOD_RESET;
         cfg_ff.blink_on_ticks     <= BLINK_ON_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DAY_TICKS:    cfg_ff.day_ticks          <= csr_data;
            REG_UNIT_TICKS:   cfg_ff.unit_ticks         <= csr_data[7:0];
            REG_BLINK_PERIOD: cfg_ff.blink_period_ticks <= csr_data[15:0];
            REG_BLINK_ON:     cfg_ff.blink_on_ticks     <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   ldwt_step u_step (
      .cfg         (cfg_ff),
      .cur_state   (state_ff),
      .button_down (req_button_down),
      .next_state  (state_in),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pump_on        = result_ff.pump_on;
   assign rsp_led_on         = result_ff.led_on;
   assign rsp_mode           = result_ff.mode;
   assign rsp_duration_units = result_ff.duration_units;

endmodule

// ----- sv/ldwt_step.sv -----
module ldwt_step import ldwt_pkg::*; (
   input  cfg_type    cfg,
   input  state_type  cur_state,
   input  logic       button_down,
   output state_type  next_state,
   output result_type result
);

   always_comb begin
      state_type                nxt;
      logic [7:0]               unit_eff;
      logic [31:0]              day_eff;
      logic [15:0]              period_eff;
      logic                     edge_seen;
      logic                     pend_v;
      logic                     pump;
      logic                     led;
      logic                     tick_en;
      logic                     tick_meas;
      logic [7:0]               base_sub;
      logic [DURATION_BITS-1:0] base_run;
      logic [DURATION_BITS-1:0] units;
      logic [DURATION_BITS-1:0] run_t;
      logic [8:0]               sub_inc;
      logic                     wrap;
      logic                     done;
      logic [31:0]              day_cnt;
      logic [16:0]              blink_inc;
      logic [15:0]              blink_next;
      logic [1:0]               shown;

      nxt        = cur_state;
      unit_eff   = (cfg.unit_ticks == 8'd0) ? 8'd1 : cfg.unit_ticks;
      day_eff    = (cfg.day_ticks == 32'd0) ? 32'd1 : cfg.day_ticks;
      period_eff = (cfg.blink_period_ticks == 16'd0) ? 16'd1 : cfg.blink_period_ticks;
      edge_seen  = button_down & ~cur_state.button_prev;
      pend_v     = cur_state.pending_press | edge_seen;
      pump       = 1'b0;
      led        = 1'b0;
      tick_en    = 1'b0;
      tick_meas  = 1'b0;
      base_sub   = cur_state.sub_ticks;
      base_run   = cur_state.run_units;
      units      = cur_state.run_units;
      day_cnt    = cur_state.day_count;
      blink_inc  = 17'd0;
      blink_next = 16'd0;
      nxt.button_prev = button_down;

      unique case (cur_state.mode)
         MODE_MEASURE: begin
            if (button_down) begin
               pump      = 1'b1;
               tick_en   = 1'b1;
               tick_meas = 1'b1;
            end else begin
               if ({cur_state.sub_ticks, 1'b0} >= {1'b0, unit_eff} && units != MAX_UNITS) begin
                  units = units + 1'b1;
               end
               nxt.stored_units  = units;
               nxt.armed         = 1'b1;
               nxt.day_count     = '0;
               nxt.blink_count   = '0;
               nxt.pending_press = 1'b0;
               nxt.sub_ticks     = '0;
               nxt.run_units     = units;
               if (units != '0) begin
                  nxt.mode = MODE_CONFIRM;
                  led      = 1'b1;
                  tick_en  = 1'b1;
                  base_sub = '0;
                  base_run = units;
               end else begin
                  nxt.mode = MODE_IDLE;
               end
            end
         end
         MODE_CONFIRM: begin
            led     = 1'b1;
            tick_en = 1'b1;
         end
         MODE_WATER: begin
            nxt.pending_press = pend_v;
            if (cur_state.day_count < day_eff) begin
               nxt.day_count = cur_state.day_count + 32'd1;
            end
            pump    = 1'b1;
            tick_en = 1'b1;
         end
         MODE_IDLE: begin
            nxt.pending_press = pend_v;
            if (cur_state.armed && cur_state.day_count < day_eff) begin
               day_cnt = cur_state.day_count + 32'd1;
            end
            nxt.day_count = day_cnt;
            if (pend_v && button_down) begin
               nxt.pending_press = 1'b0;
               nxt.mode          = MODE_MEASURE;
               base_sub          = '0;
               base_run          = '0;
               pump              = 1'b1;
               tick_en           = 1'b1;
               tick_meas         = 1'b1;
            end else if (cur_state.armed) begin
               if (day_cnt >= day_eff) begin
                  nxt.day_count = '0;
               end
               if (day_cnt >= day_eff && cur_state.stored_units != '0) begin
                  nxt.mode = MODE_WATER;
                  base_sub = '0;
                  base_run = cur_state.stored_units;
                  pump     = 1'b1;
                  tick_en  = 1'b1;
               end else begin
                  blink_inc  = {1'b0, cur_state.blink_count} + 17'd1;
                  blink_next = (blink_inc >= {1'b0, period_eff}) ? 16'd0 : blink_inc[15:0];
                  nxt.blink_count = blink_next;
                  if (cfg.blink_on_ticks != 8'd0 &&
                      ({1'b0, blink_next} + {9'd0, cfg.blink_on_ticks}) >= {1'b0, period_eff}) begin
                     led = 1'b1;
                  end
               end
            end
         end
         default: begin
            nxt.mode = MODE_IDLE;
         end
      endcase

      sub_inc = {1'b0, base_sub} + 9'd1;
      wrap    = (sub_inc >= {1'b0, unit_eff});
      run_t   = base_run;
      if (tick_meas) begin
         if (wrap && base_run != MAX_UNITS) begin
            run_t = base_run + 1'b1;
         end
      end else if (wrap && base_run != '0) begin
         run_t = base_run - 1'b1;
      end
      done = wrap && !tick_meas && run_t == '0;
      if (tick_en) begin
         nxt.sub_ticks = wrap ? 8'd0 : sub_inc[7:0];
         nxt.run_units = run_t;
         if (done) begin
            nxt.mode = MODE_IDLE;
         end
      end

      if (pump) begin
         shown = (nxt.mode == MODE_MEASURE) ? CODE_MEASURE : CODE_WATER;
      end else if (led && nxt.mode != MODE_IDLE) begin
         shown = CODE_CONFIRM;
      end else if (led) begin
         shown = (cfg.blink_on_ticks != 8'd0 && nxt.armed && nxt.sub_ticks == 8'd0 &&
                  nxt.run_units == '0) ? CODE_IDLE : CODE_CONFIRM;
      end else begin
         unique case (nxt.mode)
            MODE_MEASURE: shown = CODE_MEASURE;
            MODE_CONFIRM: shown = CODE_CONFIRM;
            MODE_WATER:   shown = CODE_WATER;
            default:      shown = CODE_IDLE;
         endcase
      end

      next_state             = nxt;
      result.pump_on         = pump;
      result.led_on          = led;
      result.mode            = shown;
      result.duration_units  = 16'(nxt.stored_units);
   end

endmodule

// ----- sv/ldwt_checker.sv -----
module ldwt_checker import ldwt_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_pump_on,
   input logic       rsp_led_on,
   input logic [1:0] rsp_mode
);

   // A result that is held back stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // Input is held back only while a finished result waits.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

   // The pump only runs while measuring or watering.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pump_on |-> rsp_mode == CODE_MEASURE || rsp_mode == CODE_WATER)
      else $error("pump on in a mode without pump");

   // Measuring always drives the pump; confirming always lights the LED.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == CODE_MEASURE |-> rsp_pump_on)
      else $error("measuring without pump");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == CODE_CONFIRM |-> rsp_led_on && !rsp_pump_on)
      else $error("confirming without LED");

endmodule

bind learned_duration_watering_timer_top ldwt_checker u_ldwt_checker (.*);

// ----- tb/sv/tb.sv -----
module tb;
   import ldwt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 100_000;
   localparam int unsigned PRINT_LIMIT = 20;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} stall_style_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_button_down;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_pump_on;
   logic                      rsp_led_on;
   logic [1:0]                rsp_mode;
   logic [15:0]               rsp_duration_units;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [31:0]               csr_data;

   learned_duration_watering_timer_top i_dut (.*);

   logic [31:0]              day_cfg;
   logic [7:0]               unit_cfg;
   logic [15:0]              period_cfg;
   logic [7:0]               on_cfg;

   logic [1:0]               mode_q;
   logic                     armed_q;
   logic [DURATION_BITS-1:0] stored_q;
   logic [7:0]               sub_q;
   logic [DURATION_BITS-1:0] run_q;
   logic [31:0]              day_q;
   logic [15:0]              blink_q;
   logic                     pending_q;
   logic                     button_q;

   bit              pending_ticks[$];
   result_type      tick_results[$];
   bit              req_taken;
   int unsigned     gap_left;
   int unsigned     burst_left;
   int unsigned     stall_left;
   stall_style_type stall_style;
   int unsigned     mismatches;
   int unsigned     cycle_count;

   function automatic logic [7:0] unit_len();
      return (unit_cfg == 8'd0) ? 8'd1 : unit_cfg;
   endfunction

   function automatic void count_held();
      sub_q++;
      if (sub_q >= unit_len()) begin
         sub_q = '0;
         if (run_q != MAX_UNITS) run_q++;
      end
   endfunction

   // Returns 1 on the tick that ends a confirmation or watering run.
   function automatic bit count_active();
      sub_q++;
      if (sub_q >= unit_len()) begin
         sub_q = '0;
         if (run_q != '0) run_q--;
         if (run_q == '0) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic result_type advance_timer(input logic btn);
      logic                     rise;
      logic [31:0]              day_len;
      logic [15:0]              per;
      logic                     pump;
      logic                     led;
      logic                     started;
      logic [1:0]               shown;
      logic [DURATION_BITS-1:0] units;
      result_type               r;
      rise    = btn && !button_q;
      day_len = (day_cfg == 32'd0) ? 32'd1 : day_cfg;
      per     = (period_cfg == 16'd0) ? 16'd1 : period_cfg;
      pump    = 1'b0;
      led     = 1'b0;
      started = 1'b0;
      button_q = btn;
      case (mode_q)
         CODE_MEASURE: begin
            if (btn) begin
               pump = 1'b1;
               count_held();
            end else begin
               units = run_q;
               if (2 * int'(sub_q) >= int'(unit_len()) && units != MAX_UNITS) units++;
               stored_q  = units;
               armed_q   = 1'b1;
               day_q     = '0;
               blink_q   = '0;
               pending_q = 1'b0;
               sub_q     = '0;
               run_q     = units;
               if (units != '0) begin
                  mode_q = CODE_CONFIRM;
                  led    = 1'b1;
                  if (count_active()) mode_q = CODE_IDLE;
               end else begin
                  mode_q = CODE_IDLE;
               end
            end
         end
         CODE_CONFIRM: begin
            led = 1'b1;
            if (count_active()) mode_q = CODE_IDLE;
         end
         CODE_WATER: begin
            if (rise) pending_q = 1'b1;
            if (day_q < day_len) day_q++;
            pump = 1'b1;
            if (count_active()) mode_q = CODE_IDLE;
         end
         default: begin
            if (rise) pending_q = 1'b1;
            if (armed_q && day_q < day_len) day_q++;
            if (pending_q && btn) begin
               pending_q = 1'b0;
               mode_q    = CODE_MEASURE;
               sub_q     = '0;
               run_q     = '0;
               pump      = 1'b1;
               count_held();
            end else if (armed_q) begin
               if (day_q >= day_len) begin
                  day_q = '0;
                  if (stored_q != '0) begin
                     mode_q  = CODE_WATER;
                     run_q   = stored_q;
                     sub_q   = '0;
                     pump    = 1'b1;
                     started = 1'b1;
                     if (count_active()) mode_q = CODE_IDLE;
                  end
               end
               if (!started) begin
                  if (32'(blink_q) + 32'd1 >= 32'(per)) blink_q = '0;
                  else blink_q++;
                  if (on_cfg != 8'd0 && 32'(blink_q) + 32'(on_cfg) >= 32'(per)) led = 1'b1;
               end
            end
         end
      endcase
      shown = mode_q;
      if (pump) begin
         shown = (mode_q == CODE_MEASURE) ? CODE_MEASURE : CODE_WATER;
      end else if (led && mode_q != CODE_IDLE) begin
         shown = CODE_CONFIRM;
      end else if (led) begin
         shown = (on_cfg != 8'd0 && armed_q && sub_q == '0 && run_q == '0) ? CODE_IDLE
                                                                           : CODE_CONFIRM;
      end
      r.pump_on        = pump;
      r.led_on         = led;
      r.mode           = shown;
      r.duration_units = 16'(stored_q);
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         if (mismatches < PRINT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
         mismatches++;
      end
   endtask

   task automatic compare_result();
      result_type want;
      if (tick_results.size() == 0) begin
         if (mismatches < PRINT_LIMIT) begin
            $display("%0t: result transfer with nothing expected, actual pump %0d led %0d",
                     $time, rsp_pump_on, rsp_led_on);
         end
         mismatches++;
      end else begin
         want = tick_results.pop_front();
         check_field("pump_on", 32'(want.pump_on), 32'(rsp_pump_on));
         check_field("led_on", 32'(want.led_on), 32'(rsp_led_on));
         check_field("mode", 32'(want.mode), 32'(rsp_mode));
         check_field("duration_units", 32'(want.duration_units), 32'(rsp_duration_units));
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DAY_TICKS:    day_cfg = csr_data;
               REG_UNIT_TICKS:   unit_cfg = csr_data[7:0];
               REG_BLINK_PERIOD: period_cfg = csr_data[15:0];
               REG_BLINK_ON:     on_cfg = csr_data[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) compare_result();
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            tick_results.push_back(advance_timer(req_button_down));
            void'(pending_ticks.pop_front());
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            req_valid       <= 1'b1;
            req_button_down <= pending_ticks[0];
            if (burst_left <= 1) begin
               if ($urandom_range(0, 3) == 0) begin
                  gap_left   = 0;
                  burst_left = $urandom_range(100, 300);
               end else begin
                  gap_left   = $urandom_range(1, 6);
                  burst_left = $urandom_range(1, 30);
               end
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_left  = $urandom_range(10, 80);
      end
      stall_left--;
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= stall_left[0];
      endcase
   end

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(input logic [31:0] day, input logic [7:0] unit,
                             input logic [15:0] period, input logic [7:0] on_len);
      write_csr(REG_DAY_TICKS, day);
      write_csr(REG_UNIT_TICKS, 32'(unit));
      write_csr(REG_BLINK_PERIOD, 32'(period));
      write_csr(REG_BLINK_ON, 32'(on_len));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_ticks.size() != 0 || tick_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic push_pattern(input string levels);
      for (int i = 0; i < levels.len(); i++) pending_ticks.push_back(levels[i] == "1");
   endtask

   // Mostly complete presses with random hold times, idle spans that can reach day ends
   // when a day is at most 28 ticks, and an occasional burst of random button noise.
   task automatic queue_usage(input int unsigned count);
      int unsigned queued;
      int unsigned len;
      int unsigned hold_max;
      int unsigned idle_max;
      int unsigned pick;
      queued   = 0;
      hold_max = (3 * int'(unit_cfg) + 2 > 200) ? 200 : 3 * int'(unit_cfg) + 2;
      idle_max = (day_cfg > 32'd28) ? 60 : 2 * int'(day_cfg) + 4;
      while (queued < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            len = $urandom_range(1, hold_max);
            repeat (len) pending_ticks.push_back(1'b1);
            pending_ticks.push_back(1'b0);
            queued += len + 1;
         end else if (pick < 9) begin
            len = $urandom_range(1, idle_max);
            repeat (len) pending_ticks.push_back(1'b0);
            queued += len;
         end else begin
            len = $urandom_range(1, 8);
            repeat (len) pending_ticks.push_back($urandom_range(0, 1) == 1);
            queued += len;
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_button_down = 1'b0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = REG_DAY_TICKS;
      csr_data        = '0;
      day_cfg         = DAY_TICKS_RESET;
      unit_cfg        = UNIT_TICKS_RESET;
      period_cfg      = BLINK_PERIOD_RESET;
      on_cfg          = BLINK_ON_RESET;
      mode_q          = CODE_IDLE;
      armed_q         = 1'b0;
      stored_q        = '0;
      sub_q           = '0;
      run_q           = '0;
      day_q           = '0;
      blink_q         = '0;
      pending_q       = 1'b0;
      button_q        = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the reset settings a half unit of hold time rounds up to one unit.
      push_pattern("00111110000");
      drain();
      // A day end starts a run, and a press during the run is held until idle.
      set_config(32'd3, 8'd2, 16'd2, 8'd1);
      push_pattern("01000001101000");
      drain();
      // A short hold rounds to zero units, and a long pulse keeps the LED lit.
      set_config(32'd2, 8'd4, 16'd3, 8'd3);
      push_pattern("1001100000");
      drain();

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: set_config(32'd1, 8'd1, 16'd1, 8'd1);
            1: set_config(32'hFFFF_FFFF, 8'd255, 16'hFFFF, 8'd255);
            2: set_config(32'd5, 8'd3, 16'd4, 8'd255);
            3: set_config(32'd20, 8'd1, 16'hFFFF, 8'd1);
            default: set_config(32'($urandom_range(1, 40)), 8'($urandom_range(1, 6)),
                                16'($urandom_range(1, 12)), 8'($urandom_range(1, 14)));
         endcase
         queue_usage(130);
         drain();
      end

      if (mismatches == 0 && tick_results.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
